FILE: rtl/ntc_pkg.sv
package ntc_pkg;

    localparam int unsigned LOG_FRAC  = 24;
    localparam int unsigned MANT_FRAC = 30;
    localparam int unsigned LOG_W     = 29;
    localparam int unsigned QUOT_W    = 18;

    localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;
    localparam logic signed [18:0] ZERO_C_CENTIK = 19'sd27315;
    localparam logic signed [17:0] TEMP_MAX = 18'sd100000;
    localparam logic signed [17:0] TEMP_MIN = -18'sd27315;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_ADC_BITS = 3'd0;
    localparam logic [2:0] REG_T0       = 3'd1;
    localparam logic [2:0] REG_R0       = 3'd2;
    localparam logic [2:0] REG_BETA     = 3'd3;
    localparam logic [2:0] REG_R1       = 3'd4;
    localparam logic [2:0] REG_VIN      = 3'd5;

    typedef struct packed {
        logic       special;
        logic [1:0] status;
    } side_t;

    function automatic logic [LOG_FRAC:0] log_entry(input int i, input int tb);
        logic [63:0]       m;
        logic [LOG_FRAC:0] acc;
        int                k;
        m   = (64'(1 << tb) + 64'(i)) << (MANT_FRAC - tb);
        acc = '0;
        if (m >= (64'd1 << (MANT_FRAC + 1)))
        begin
            return (LOG_FRAC + 1)'(1 << LOG_FRAC);
        end
        for (k = 1; k <= int'(LOG_FRAC); k++)
        begin
            m = (m * m) >> MANT_FRAC;
            if (m >= (64'd1 << (MANT_FRAC + 1)))
            begin
                m = m >> 1;
                acc[LOG_FRAC - k] = 1'b1;
            end
        end
        return acc;
    endfunction

endpackage

FILE: rtl/ntc_if.sv
interface ntc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] adc_sample;
    modport source(output valid, output adc_sample, input ready);
    modport sink(input valid, input adc_sample, output ready);
endinterface

interface ntc_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] temp_centi_c;
    logic [1:0]         status;
    modport source(output valid, output temp_centi_c, output status, input ready);
    modport sink(input valid, input temp_centi_c, input status, output ready);
endinterface

FILE: rtl/ntc_beta_temperature_core.sv
// Channel  Direction  Payload
// sample   in         adc_sample[15:0]
// result   out        temp_centi_c[17:0] signed, status[1:0]
// cfg      in         cfg_we, cfg_index[2:0], cfg_data[23:0]
//
// One request per cycle is accepted while the result is not stalled.
// Samples pass through the log and multiply stages and then the 18-stage restoring divider.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stalled result holds every stage; nothing is dropped or repeated.
module ntc_beta_temperature_core #(
    parameter int LN_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    ntc_in_if.sink      sample,
    ntc_out_if.source   result
);

    logic [4:0]  adc_bits_reg;
    logic [16:0] t0_reg;
    logic [23:0] r0_reg;
    logic [15:0] beta_reg;
    logic [23:0] r1_reg;
    logic [15:0] vin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_bits_reg <= 5'd10;
            t0_reg       <= 17'd29815;
            r0_reg       <= 24'd10000;
            beta_reg     <= 16'd3950;
            r1_reg       <= 24'd10000;
            vin_reg      <= 16'd5000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ntc_pkg::REG_ADC_BITS: adc_bits_reg <= cfg_data[4:0];
                ntc_pkg::REG_T0:       t0_reg       <= cfg_data[16:0];
                ntc_pkg::REG_R0:       r0_reg       <= cfg_data;
                ntc_pkg::REG_BETA:     beta_reg     <= cfg_data[15:0];
                ntc_pkg::REG_R1:       r1_reg       <= cfg_data;
                ntc_pkg::REG_VIN:      vin_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic        en;
    logic        out_valid_reg;
    logic [4:0]  bits;
    logic [16:0] full;
    logic [16:0] t0;
    logic [15:0] b;
    logic [22:0] b100;

    assign en           = !out_valid_reg || result.ready;
    assign sample.ready = en;

    always_comb
    begin
        bits = adc_bits_reg;
        if (adc_bits_reg < 5'd8)
        begin
            bits = 5'd8;
        end
        if (adc_bits_reg > 5'd16)
        begin
            bits = 5'd16;
        end
        full = 17'd1 << bits;
        t0   = (t0_reg == 17'd0) ? 17'd1 : t0_reg;
        b    = (beta_reg == 16'd0) ? 16'd1 : beta_reg;
        b100 = 23'(b) * 23'd100;
    end

    logic [9:0]  v_reg;
    logic [8:0]  full_reg;
    logic [16:0] m0_reg, den0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:0], sample.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= 17'(sample.adc_sample & 16'(full - 17'd1)) + 17'd1;
            den0_reg <= full - (17'(sample.adc_sample & 16'(full - 17'd1)) + 17'd1);
            full_reg <= {full_reg[7:0],
                         (full - (17'(sample.adc_sample & 16'(full - 17'd1)) + 17'd1)) == 17'd0};
        end
    end

    logic [ntc_pkg::LOG_W-1:0] y_r1, y_m, y_den, y_r0;

    ntc_log2 #(.TB(LN_TABLE_BITS)) u_log_r1 (
        .clk(clk), .en(en), .x(r1_reg), .y(y_r1));
    ntc_log2 #(.TB(LN_TABLE_BITS)) u_log_m (
        .clk(clk), .en(en), .x(24'(m0_reg)), .y(y_m));
    ntc_log2 #(.TB(LN_TABLE_BITS)) u_log_den (
        .clk(clk), .en(en), .x(24'(den0_reg)), .y(y_den));
    ntc_log2 #(.TB(LN_TABLE_BITS)) u_log_r0 (
        .clk(clk), .en(en), .x(r0_reg), .y(y_r0));

    logic signed [31:0] l2_reg;
    logic signed [61:0] p6_reg;
    logic signed [61:0] bias;
    logic signed [29:0] lnq;
    logic signed [47:0] mt7_reg;
    logic [39:0]        nb7_reg;
    logic signed [48:0] d8_reg;
    logic [59:0]        num8_reg;
    logic [61:0]        a9_reg;
    logic [47:0]        d9_reg;
    ntc_pkg::side_t     side9_reg;
    ntc_pkg::side_t     side9_next;

    always_comb
    begin
        bias = p6_reg[61] ? 62'sd17179869183 : 62'sd0;
        lnq  = 30'((p6_reg + bias) >>> 34);
        side9_next = '{special: 1'b0, status: ntc_pkg::ST_VALID};
        if (full_reg[8])
        begin
            side9_next = '{special: 1'b1, status: ntc_pkg::ST_OPEN};
        end
        else if (d8_reg[48] || d8_reg == 49'sd0)
        begin
            side9_next = '{special: 1'b1, status: ntc_pkg::ST_RANGE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_reg    <= $signed({3'd0, y_r1}) + $signed({3'd0, y_m})
                         - $signed({3'd0, y_den}) - $signed({3'd0, y_r0});
            p6_reg    <= 62'(l2_reg) * 62'(ntc_pkg::LN2_Q30);
            mt7_reg   <= 48'(lnq) * 48'($signed({1'b0, t0}));
            nb7_reg   <= 40'(b100) * 40'(t0);
            d8_reg    <= 49'(mt7_reg) + $signed({6'd0, b100, 20'd0});
            num8_reg  <= {nb7_reg, 20'd0};
            a9_reg    <= 62'(num8_reg) + 62'(d8_reg[47:1]);
            d9_reg    <= d8_reg[47:0];
            side9_reg <= side9_next;
        end
    end

    logic                       dv;
    logic [ntc_pkg::QUOT_W-1:0] q;
    ntc_pkg::side_t             dside;

    ntc_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_reg[9]),
        .a(a9_reg), .d(d9_reg), .side_in(side9_reg),
        .out_valid(dv), .q(q), .side_out(dside));

    logic signed [18:0] tcs;
    logic signed [17:0] temp_next;
    logic [1:0]         status_next;
    logic signed [17:0] temp_reg;
    logic [1:0]         status_reg;

    always_comb
    begin
        tcs         = $signed({1'b0, q}) - ntc_pkg::ZERO_C_CENTIK;
        temp_next   = tcs[17:0];
        status_next = ntc_pkg::ST_VALID;
        if (dside.special)
        begin
            status_next = dside.status;
            temp_next   = (dside.status == ntc_pkg::ST_OPEN) ? ntc_pkg::TEMP_MIN
                                                              : ntc_pkg::TEMP_MAX;
        end
        else if (tcs > 19'(ntc_pkg::TEMP_MAX))
        begin
            temp_next   = ntc_pkg::TEMP_MAX;
            status_next = ntc_pkg::ST_RANGE;
        end
        else if (tcs < 19'(ntc_pkg::TEMP_MIN))
        begin
            temp_next   = ntc_pkg::TEMP_MIN;
            status_next = ntc_pkg::ST_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.temp_centi_c = temp_reg;
    assign result.status       = status_reg;

    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v_reg[0])
        else $error("accepted request missing from first stage");

    a_open_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ntc_pkg::ST_OPEN |->
        result.temp_centi_c == ntc_pkg::TEMP_MIN)
        else $error("open divider without minimum temperature");

    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ntc_pkg::ST_RANGE |->
        result.temp_centi_c == ntc_pkg::TEMP_MAX || result.temp_centi_c == ntc_pkg::TEMP_MIN)
        else $error("saturation status without saturated value");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.temp_centi_c <= ntc_pkg::TEMP_MAX
        && result.temp_centi_c >= ntc_pkg::TEMP_MIN && result.status != 2'd3)
        else $error("result outside range");

endmodule

FILE: rtl/ntc_log2.sv
module ntc_log2 #(
    parameter int TB = 8
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [23:0]                 x,
    output logic [ntc_pkg::LOG_W-1:0]   y
);

    localparam int SH = ntc_pkg::MANT_FRAC - TB;
    localparam int TW = ntc_pkg::LOG_FRAC + 1;

    logic [TW-1:0] tab [0:2**TB];

    for (genvar g = 0; g <= 2**TB; g++)
    begin : g_tab
        assign tab[g] = ntc_pkg::log_entry(g, TB);
    end

    logic [23:0] xx;
    logic [4:0]  e;
    logic [30:0] u;

    always_comb
    begin
        xx = (x == 24'd0) ? 24'd1 : x;
        e  = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (xx[i])
            begin
                e = 5'(i);
            end
        end
        u = 31'(xx) << (5'd30 - e);
    end

    logic [4:0]      e1_reg, e2_reg, e3_reg;
    logic [TB-1:0]   idx1_reg;
    logic [SH-1:0]   r1_reg, r2_reg;
    logic [TW-1:0]   lo2_reg, lo3_reg, diff2_reg, interp3_reg;
    logic [TW+SH-1:0] prod_next;
    logic [ntc_pkg::LOG_W-1:0] y_reg;

    assign prod_next = (TW + SH)'(diff2_reg) * (TW + SH)'(r2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg      <= e;
            idx1_reg    <= u[29:SH];
            r1_reg      <= u[SH-1:0];
            e2_reg      <= e1_reg;
            lo2_reg     <= tab[(TB + 1)'(idx1_reg)];
            diff2_reg   <= tab[(TB + 1)'(idx1_reg) + (TB + 1)'(1)] - tab[(TB + 1)'(idx1_reg)];
            r2_reg      <= r1_reg;
            e3_reg      <= e2_reg;
            lo3_reg     <= lo2_reg;
            interp3_reg <= TW'(prod_next >> SH);
            y_reg       <= {e3_reg, 24'd0} + ntc_pkg::LOG_W'(lo3_reg)
                           + ntc_pkg::LOG_W'(interp3_reg);
        end
    end

    assign y = y_reg;

endmodule

FILE: rtl/ntc_div.sv
module ntc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [61:0]                   a,
    input  logic [47:0]                   d,
    input  ntc_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [ntc_pkg::QUOT_W-1:0]    q,
    output ntc_pkg::side_t                side_out
);

    localparam int N = ntc_pkg::QUOT_W;

    logic                valid_reg [0:N];
    logic [65:0]         rem_reg   [0:N-1];
    logic [47:0]         d_reg     [0:N-1];
    logic [N-1:0]        q_reg     [0:N];
    ntc_pkg::side_t      side_reg  [0:N];
    logic [65:0]         dk        [0:N-1];
    logic [N-1:0]        take;

    logic           ovf;
    ntc_pkg::side_t side0;

    always_comb
    begin
        ovf   = {4'd0, a} >= {d, 18'd0};
        side0 = side_in;
        if (!side_in.special && ovf)
        begin
            side0.special = 1'b1;
            side0.status  = ntc_pkg::ST_RANGE;
        end
        for (int s = 0; s < N; s++)
        begin
            dk[s]   = {18'd0, d_reg[s]} << (N - 1 - s);
            take[s] = rem_reg[s] >= dk[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 0; s < N; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {4'd0, a};
            d_reg[0]    <= d;
            q_reg[0]    <= '0;
            side_reg[0] <= side0;
            for (int s = 0; s < N; s++)
            begin
                if (s < N - 1)
                begin
                    rem_reg[s+1] <= take[s] ? rem_reg[s] - dk[s] : rem_reg[s];
                    d_reg[s+1]   <= d_reg[s];
                end
                q_reg[s+1]    <= q_reg[s] | (N'(take[s]) << (N - 1 - s));
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign q         = q_reg[N];
    assign side_out  = side_reg[N];

endmodule

FILE: test/tb_ntc_beta_temperature_core.sv
typedef struct {
    logic signed [17:0] temp;
    logic [1:0]         status;
} reading_t;

class temp_scoreboard;
    localparam int TB_BITS = 8;
    bit [24:0]          log2_frac[(1 << TB_BITS) + 1];
    bit [4:0]           adc_bits;
    bit [16:0]          t0;
    bit [23:0]          r0;
    bit [15:0]          beta;
    bit [23:0]          r1;
    bit [15:0]          vin;
    reading_t           pending[$];
    int                 errors;
    int                 checked;
    int                 open_seen;
    int                 range_seen;

    function new();
        longint unsigned m;
        bit [24:0]       acc;
        for (int i = 0; i <= (1 << TB_BITS); i++)
        begin
            m   = longint'((1 << TB_BITS) + i) << (30 - TB_BITS);
            acc = '0;
            if (m >= (64'd1 << 31))
            begin
                acc = 25'd1 << 24;
            end
            else
            begin
                for (int k = 1; k <= 24; k++)
                begin
                    m = (m * m) >> 30;
                    if (m >= (64'd1 << 31))
                    begin
                        m = m >> 1;
                        acc[24 - k] = 1'b1;
                    end
                end
            end
            log2_frac[i] = acc;
        end
        adc_bits = 5'd10;
        t0       = 17'd29815;
        r0       = 24'd10000;
        beta     = 16'd3950;
        r1       = 24'd10000;
        vin      = 16'd5000;
        errors   = 0;
        checked  = 0;
        open_seen  = 0;
        range_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] v);
        case (idx)
            ntc_pkg::REG_ADC_BITS: adc_bits = v[4:0];
            ntc_pkg::REG_T0:       t0       = v[16:0];
            ntc_pkg::REG_R0:       r0       = v;
            ntc_pkg::REG_BETA:     beta     = v[15:0];
            ntc_pkg::REG_R1:       r1       = v;
            ntc_pkg::REG_VIN:      vin      = v[15:0];
            default: ;
        endcase
    endfunction

    function longint log2_q24(longint unsigned x);
        int              e;
        longint unsigned f;
        longint unsigned idx;
        longint unsigned r;
        longint unsigned lo;
        longint unsigned hi;
        e = 0;
        if (x == 0)
        begin
            x = 1;
        end
        while (e < 40 && (x >> (e + 1)) != 0)
        begin
            e++;
        end
        f   = (x << (30 - e)) - (64'd1 << 30);
        idx = (f >> (30 - TB_BITS)) & ((1 << TB_BITS) - 1);
        r   = f & ((64'd1 << (30 - TB_BITS)) - 1);
        lo  = log2_frac[idx];
        hi  = log2_frac[idx + 1];
        return longint'((longint'(e) << 24) + lo + (((hi - lo) * r) >> (30 - TB_BITS)));
    endfunction

    function reading_t convert(logic [15:0] s);
        reading_t        res;
        int              bits;
        longint unsigned full;
        longint unsigned n;
        longint unsigned den;
        longint          l2;
        longint          lnq;
        longint          d;
        longint          num;
        longint          tc;
        longint          temp;
        longint          t0v;
        longint          bv;
        t0v  = (t0 == 0) ? 1 : t0;
        bv   = (beta == 0) ? 1 : beta;
        bits = adc_bits;
        if (bits < 8) bits = 8;
        if (bits > 16) bits = 16;
        full = 64'd1 << bits;
        n    = s & (full - 1);
        den  = full - (n + 1);
        res.status = ntc_pkg::ST_VALID;
        if (den == 0)
        begin
            temp = -27315;
            res.status = ntc_pkg::ST_OPEN;
        end
        else
        begin
            l2  = log2_q24((r1 == 0) ? 1 : r1) + log2_q24(n + 1) - log2_q24(den)
                  - log2_q24((r0 == 0) ? 1 : r0);
            lnq = (l2 * 64'sd744261118) / (64'sd1 <<< 34);
            d   = lnq * t0v + (100 * bv) * (64'sd1 <<< 20);
            if (d <= 0)
            begin
                temp = 100000;
                res.status = ntc_pkg::ST_RANGE;
            end
            else
            begin
                num  = (100 * bv * t0v) * (64'sd1 <<< 20);
                tc   = (num + d / 2) / d;
                temp = tc - 27315;
                if (temp > 100000)
                begin
                    temp = 100000;
                    res.status = ntc_pkg::ST_RANGE;
                end
                else if (temp < -27315)
                begin
                    temp = -27315;
                    res.status = ntc_pkg::ST_RANGE;
                end
            end
        end
        res.temp = temp[17:0];
        return res;
    endfunction

    function void note_sample(logic [15:0] s);
        pending.push_back(convert(s));
    endfunction

    function void check_reading(logic signed [17:0] t, logic [1:0] st);
        reading_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result temp_centi_c=%0d status=%0d", t, st);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (st == ntc_pkg::ST_OPEN) open_seen++;
        if (st == ntc_pkg::ST_RANGE) range_seen++;
        if (t !== want.temp)
        begin
            $error("temp_centi_c expected %0d actual %0d", want.temp, t);
            errors++;
        end
        if (st !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, st);
            errors++;
        end
    endfunction
endclass

module tb_ntc_beta_temperature_core;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    int          samples_sent;
    temp_scoreboard board;

    ntc_in_if  sample();
    ntc_out_if result();

    ntc_beta_temperature_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .result    (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
            result.ready <= 1'b0;
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            board.check_reading(result.temp_centi_c, result.status);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample.valid && sample.ready) || (result.valid && result.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == 5000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic send_sample(logic [15:0] s);
        sample.valid      <= 1'b1;
        sample.adc_sample <= s;
        @(posedge clk);
        while (!sample.ready)
        begin
            @(posedge clk);
        end
        board.note_sample(s);
        samples_sent++;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
    endtask

    function automatic logic [23:0] pick_value(int hi_bits, int lo_v, int hi_v, int typ);
        case ($urandom_range(5))
            0: return 24'(lo_v);
            1: return 24'(hi_v);
            2: return 24'd0;
            3: return 24'(typ);
            default: return 24'($urandom) & ((24'd1 << hi_bits) - 1);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        int bits;
        bits = board.adc_bits < 8 ? 8 : (board.adc_bits > 16 ? 16 : board.adc_bits);
        case ($urandom_range(7))
            0: return 16'($urandom) | 16'((1 << bits) - 1);
            1: return 16'((1 << bits) - 1 - $urandom_range(3));
            2: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        board             = new();
        rst_n             = 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        sample.valid      <= 1'b0;
        sample.adc_sample <= '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        samples_sent      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd512);
        send_sample(16'd1022);
        send_sample(16'd1023);
        send_sample(16'hFFFF);
        send_sample(16'hFC00);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain();
        // large R1 over a tiny R0 drives readings toward the cold end
        write_reg(ntc_pkg::REG_R1, 24'hFFFFFF);
        write_reg(ntc_pkg::REG_R0, 24'd1);
        send_sample(16'd1022);
        send_sample(16'd0);
        drain();
        write_reg(ntc_pkg::REG_R1, 24'd1);
        write_reg(ntc_pkg::REG_R0, 24'hFFFFFF);
        write_reg(ntc_pkg::REG_BETA, 24'd1);
        send_sample(16'd0);
        send_sample(16'd200);
        drain();
        write_reg(ntc_pkg::REG_ADC_BITS, 24'd0);
        write_reg(ntc_pkg::REG_T0, 24'd0);
        write_reg(ntc_pkg::REG_R0, 24'd0);
        write_reg(ntc_pkg::REG_BETA, 24'd0);
        write_reg(ntc_pkg::REG_R1, 24'd0);
        write_reg(ntc_pkg::REG_VIN, 24'd0);
        send_sample(16'd255);
        send_sample(16'd100);
        drain();
        write_reg(ntc_pkg::REG_ADC_BITS, 24'd31);
        write_reg(ntc_pkg::REG_T0, 24'd100000);
        write_reg(ntc_pkg::REG_BETA, 24'd65535);
        write_reg(ntc_pkg::REG_VIN, 24'd65535);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'd0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(ntc_pkg::REG_ADC_BITS, pick_value(5, 8, 16, 10));
            write_reg(ntc_pkg::REG_T0, pick_value(17, 1, 100000, 29815));
            write_reg(ntc_pkg::REG_R0, pick_value(24, 1, 16777215, 10000));
            write_reg(ntc_pkg::REG_BETA, pick_value(16, 1, 65535, 3950));
            write_reg(ntc_pkg::REG_R1, pick_value(24, 1, 16777215, 10000));
            write_reg(ntc_pkg::REG_VIN, pick_value(16, 1, 65535, 5000));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int k = 0; k < 100; k++)
            begin
                send_sample(pick_sample());
                if (ph == 3 && k == 50)
                begin
                    // hold until the pipeline is empty
                    sample.valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            drain();
        end

        if (board.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", board.pending.size());
            board.errors++;
        end
        $display("Ran %0d samples over 13 register settings; %0d results checked",
                 samples_sent, board.checked);
        $display("Open-divider results: %0d, saturated results: %0d",
                 board.open_seen, board.range_seen);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
